// ----- rtl/box_mean_filter_clipped_assert.svh -----
// Assertion macros used by the box mean filter sequencer.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BOX_MEAN_FILTER_CLIPPED_ASSERT_SVH
`define BOX_MEAN_FILTER_CLIPPED_ASSERT_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bmf_pkg.sv -----
// Shared types and constants of the clipped box mean filter.
// No dependencies.
package bmf_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int HGT_W      = 13;
	localparam int WID_CFG_W  = 9;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WINIT,
		ST_RD,
		ST_ACC,
		ST_DIVS,
		ST_DIV,
		ST_LOAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic win_init;
		logic rd;
		logic acc;
		logic div_start;
		logic div_step;
		logic out_load;
		logic next_centre;
	} cmd_t;

	typedef struct packed {
		logic span_ok;
		logic win_last;
		logic div_done;
		logic centre_last;
	} sts_t;

endpackage

// ----- rtl/bmf_if.sv -----
// Channel interfaces: pixel input, result output, configuration write.
// Uses bmf_pkg for field widths.
interface bmf_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bmf_pkg::PIX_W-1:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface bmf_res_if #(parameter int COL_W = 8);
	logic                      valid;
	logic                      ready;
	logic [bmf_pkg::PIX_W-1:0] mean_value;
	logic [COL_W-1:0]          center_col;
	logic [bmf_pkg::ROW_W-1:0] center_row;
	logic                      last_of_run;
	modport source (output valid, output mean_value, output center_col,
		output center_row, output last_of_run, input ready);
	modport sink (input valid, input mean_value, input center_col,
		input center_row, input last_of_run, output ready);
endinterface

interface bmf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bmf_pkg::CFG_IDX_W-1:0]  index;
	logic [bmf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bmf_ctrl.sv -----
// Sequencer for the box mean filter: walks centres, window pixels and divide.
// Uses bmf_pkg and the assertion macro header.
`include "box_mean_filter_clipped_assert.svh"

module bmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bmf_pkg::sts_t sts,
	output bmf_pkg::cmd_t cmd
);

	bmf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			bmf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = bmf_pkg::ST_CHECK;
				end
			end
			bmf_pkg::ST_CHECK: begin
				state_d = sts.span_ok ? bmf_pkg::ST_WINIT : bmf_pkg::ST_IDLE;
			end
			bmf_pkg::ST_WINIT: begin
				cmd.win_init = 1'b1;
				state_d      = bmf_pkg::ST_RD;
			end
			bmf_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = bmf_pkg::ST_ACC;
			end
			bmf_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.win_last ? bmf_pkg::ST_DIVS : bmf_pkg::ST_RD;
			end
			bmf_pkg::ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = bmf_pkg::ST_DIV;
			end
			bmf_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = bmf_pkg::ST_LOAD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			bmf_pkg::ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = bmf_pkg::ST_OUT;
			end
			bmf_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.centre_last) begin
						state_d = bmf_pkg::ST_IDLE;
					end else begin
						cmd.next_centre = 1'b1;
						state_d         = bmf_pkg::ST_WINIT;
					end
				end
			end
			default: begin
				state_d = bmf_pkg::ST_IDLE;
			end
		endcase
	end

	`BMF_ASSERT_NOW(a_one_side, out_valid, !in_ready, "input taken while a word is pending")
	`BMF_ASSERT_NXT(a_take_check, cmd.take, state_q == bmf_pkg::ST_CHECK, "take not followed by check")
	`BMF_ASSERT_NOW(a_load_after_div, state_q == bmf_pkg::ST_LOAD, $past(sts.div_done),
		"result loaded before divide finished")

endmodule

// ----- rtl/bmf_datapath.sv -----
// Datapath: geometry registers, position counters, line store, window
// accumulator, restoring divider and result registers. Uses bmf_pkg.
module bmf_datapath #(
	parameter int RADIUS    = 3,
	parameter int MAX_WIDTH = 256,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [bmf_pkg::PIX_W-1:0]       pixel_in,
	input  bmf_pkg::cmd_t                   cmd,
	output bmf_pkg::sts_t                   sts,
	output logic [bmf_pkg::PIX_W-1:0]       mean_value,
	output logic [COL_W-1:0]                center_col,
	output logic [bmf_pkg::ROW_W-1:0]       center_row,
	output logic                            last_of_run
);

	localparam int WIN    = 2 * RADIUS + 1;
	localparam int SLOT_W = $clog2(WIN);
	localparam int EW     = COL_W + 1;
	localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
	localparam int CNT_W  = $clog2(WIN * WIN + 1);
	localparam int DC_W   = $clog2(SUM_W + 1);
	localparam int RW     = bmf_pkg::ROW_W;
	localparam int HW     = bmf_pkg::HGT_W;

	logic [bmf_pkg::WID_CFG_W-1:0] width_q;
	logic [HW-1:0]                 height_q;
	logic [EW-1:0]                 col_q;
	logic [RW-1:0]                 row_q;
	logic [SLOT_W-1:0]             slot_q;

	logic [bmf_pkg::PIX_W-1:0] mem [WIN][MAX_WIDTH];
	logic [bmf_pkg::PIX_W-1:0] rdata_q;

	logic [COL_W-1:0]  cx_q, cx0_q, cx1_q, xx_q;
	logic [RW-1:0]     cy_q, cy1_q, ycur_q, yy_q;
	logic [SLOT_W-1:0] yslot_q, ys_q;
	logic              span_ok_q;
	logic [SUM_W-1:0]  sum_q, q_q;
	logic [CNT_W-1:0]  cnt_q, rem_q;
	logic [DC_W-1:0]   dc_q;

	logic [EW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(WIN - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(bmf_pkg::MAX_HEIGHT)) begin
			h_eff = HW'(bmf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// position of the arriving pixel, after any wrap from a size change
	logic              wrap_c, wrap_r;
	logic [COL_W-1:0]  px;
	logic [HW-1:0]     yr;
	logic [RW-1:0]     py;
	logic [SLOT_W-1:0] psl, sl_a;
	logic [EW-1:0]     nc;
	logic [HW-1:0]     ny;
	logic [EW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic [SLOT_W-1:0] slot_n;
	logic              okx, oky;
	logic [COL_W-1:0]  pcx0, pcx1;
	logic [RW-1:0]     pcy0, pcy1;

	always_comb begin
		wrap_c = col_q >= w_eff;
		px     = wrap_c ? '0 : col_q[COL_W-1:0];
		yr     = wrap_c ? HW'(row_q) + HW'(1) : HW'(row_q);
		wrap_r = yr >= h_eff;
		py     = wrap_r ? '0 : yr[RW-1:0];
		sl_a   = wrap_c ? slot_inc(slot_q) : slot_q;
		psl    = wrap_r ? '0 : sl_a;

		nc = EW'(px) + EW'(1);
		ny = HW'(py) + HW'(1);
		if (nc >= w_eff) begin
			col_n = '0;
			if (ny >= h_eff) begin
				row_n  = '0;
				slot_n = '0;
			end else begin
				row_n  = ny[RW-1:0];
				slot_n = slot_inc(psl);
			end
		end else begin
			col_n  = nc;
			row_n  = py;
			slot_n = psl;
		end

		if (nc < w_eff) begin
			okx  = px >= COL_W'(RADIUS);
			pcx0 = px - COL_W'(RADIUS);
			pcx1 = px - COL_W'(RADIUS);
		end else begin
			okx  = 1'b1;
			pcx0 = (px >= COL_W'(RADIUS)) ? px - COL_W'(RADIUS) : '0;
			pcx1 = px;
		end
		if (ny < h_eff) begin
			oky  = py >= RW'(RADIUS);
			pcy0 = py - RW'(RADIUS);
			pcy1 = py - RW'(RADIUS);
		end else begin
			oky  = 1'b1;
			pcy0 = (py >= RW'(RADIUS)) ? py - RW'(RADIUS) : '0;
			pcy1 = py;
		end
	end

	// window bounds of the current centre
	logic [COL_W-1:0]  x0, x1;
	logic [RW-1:0]     y0, y1, yd;
	logic [SLOT_W:0]   ys_t;
	logic [SLOT_W-1:0] ys0;

	always_comb begin
		x0 = (cx_q >= COL_W'(RADIUS)) ? cx_q - COL_W'(RADIUS) : '0;
		x1 = (EW'(cx_q) + EW'(RADIUS) < w_eff) ? cx_q + COL_W'(RADIUS)
			: COL_W'(w_eff - EW'(1));
		y0 = (cy_q >= RW'(RADIUS)) ? cy_q - RW'(RADIUS) : '0;
		y1 = (HW'(cy_q) + HW'(RADIUS) < h_eff) ? cy_q + RW'(RADIUS)
			: RW'(h_eff - HW'(1));
		yd   = ycur_q - y0;
		ys_t = (SLOT_W + 1)'(yslot_q) + (SLOT_W + 1)'(WIN) - (SLOT_W + 1)'(yd);
		ys0  = (ys_t >= (SLOT_W + 1)'(WIN)) ? SLOT_W'(ys_t - (SLOT_W + 1)'(WIN))
			: SLOT_W'(ys_t);
	end

	// restoring divide step
	logic [CNT_W:0]   trial;
	logic             ge;
	logic [CNT_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, q_q[SUM_W-1]};
		ge    = trial >= (CNT_W + 1)'(cnt_q);
		rem_n = ge ? CNT_W'(trial - (CNT_W + 1)'(cnt_q)) : CNT_W'(trial);
	end

	assign sts.span_ok     = span_ok_q;
	assign sts.win_last    = (xx_q == x1) && (yy_q == y1);
	assign sts.div_done    = dc_q == '0;
	assign sts.centre_last = (cx_q == cx1_q) && (cy_q == cy1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmf_pkg::WID_CFG_W'(256);
			height_q <= HW'(256);
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bmf_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[bmf_pkg::WID_CFG_W-1:0];
					bmf_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				col_q  <= col_n;
				row_q  <= row_n;
				slot_q <= slot_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mem[psl][px] <= pixel_in;
		end
		if (cmd.rd) begin
			rdata_q <= mem[ys_q][xx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			span_ok_q <= okx && oky;
			cx_q      <= pcx0;
			cx0_q     <= pcx0;
			cx1_q     <= pcx1;
			cy_q      <= pcy0;
			cy1_q     <= pcy1;
			ycur_q    <= py;
			yslot_q   <= psl;
		end
		if (cmd.next_centre) begin
			if (cx_q == cx1_q) begin
				cx_q <= cx0_q;
				cy_q <= cy_q + RW'(1);
			end else begin
				cx_q <= cx_q + COL_W'(1);
			end
		end
		if (cmd.win_init) begin
			xx_q  <= x0;
			yy_q  <= y0;
			ys_q  <= ys0;
			sum_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.acc) begin
			sum_q <= sum_q + SUM_W'(rdata_q);
			cnt_q <= cnt_q + CNT_W'(1);
			if (xx_q == x1) begin
				xx_q <= x0;
				yy_q <= yy_q + RW'(1);
				ys_q <= slot_inc(ys_q);
			end else begin
				xx_q <= xx_q + COL_W'(1);
			end
		end
		if (cmd.div_start) begin
			q_q   <= sum_q;
			rem_q <= '0;
			dc_q  <= DC_W'(SUM_W);
		end
		if (cmd.div_step) begin
			q_q   <= {q_q[SUM_W-2:0], ge};
			rem_q <= rem_n;
			dc_q  <= dc_q - DC_W'(1);
		end
		if (cmd.out_load) begin
			mean_value  <= q_q[bmf_pkg::PIX_W-1:0];
			center_col  <= cx_q;
			center_row  <= cy_q;
			last_of_run <= (cx_q == cx1_q) && (cy_q == cy1_q);
		end
	end

endmodule

// ----- rtl/box_mean_filter_clipped.sv -----
// Clipped box mean filter, top level: sequencer plus datapath.
// Uses bmf_pkg, bmf_if, bmf_ctrl and bmf_datapath.
//
//  channel | dir | handshake    | word
//  pix     | in  | valid/ready  | pixel_in
//  res     | out | valid/ready  | mean_value, center_col, center_row, last_of_run
//  cfg     | in  | valid/ready  | index, data (0 width, 1 height)
//
// A pixel that completes no window returns the sequencer to idle. Each completed
// centre reads its N in-image window pixels through one line store read port,
// then divides with a one-bit-a-cycle divider over SUM_W bits (SUM_W = 14 at radius 3).
// Pixels are taken one at a time; a pending result holds off new pixels.
// arst_n clears counters and geometry (256 x 256); the line store is not cleared.
module box_mean_filter_clipped #(
	parameter int RADIUS    = 3,
	parameter int MAX_WIDTH = 256
) (
	input logic  clk,
	input logic  arst_n,
	bmf_pix_if.sink   pix,
	bmf_res_if.source res,
	bmf_cfg_if.sink   cfg
);

	bmf_pkg::cmd_t cmd;
	bmf_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	bmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bmf_datapath #(
		.RADIUS    (RADIUS),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.pixel_in    (pix.pixel_in),
		.cmd         (cmd),
		.sts         (sts),
		.mean_value  (res.mean_value),
		.center_col  (res.center_col),
		.center_row  (res.center_row),
		.last_of_run (res.last_of_run)
	);

endmodule

// ----- verif/bmf_checker.sv -----
// Checker for the clipped box mean filter: watches the pixel, result and config channels,
// predicts every result from its own line store copy and compares field by field.
// Depends on bmf_pkg and the channel interfaces in bmf_if.
`timescale 1ns / 1ps
module bmf_checker #(
	parameter int RADIUS    = 3,
	parameter int MAX_WIDTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	bmf_pix_if   pix,
	bmf_res_if   res,
	bmf_cfg_if   cfg,
	output int   fail_cnt,
	output int   pending,
	output int   result_cnt
);

	localparam int WIN_ROWS = 2 * RADIUS + 1;

	typedef struct {
		logic [bmf_pkg::PIX_W-1:0] mean;
		logic [7:0]                col;
		logic [bmf_pkg::ROW_W-1:0] row;
		logic                      last;
	} mean_word_t;

	mean_word_t                    mean_q[$];
	logic [bmf_pkg::PIX_W-1:0]     line_mem [WIN_ROWS*MAX_WIDTH];
	logic [bmf_pkg::WID_CFG_W-1:0] width_reg;
	logic [bmf_pkg::HGT_W-1:0]     height_reg;
	int col_pos, row_pos;

	function automatic int span_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int span_height();
		if (height_reg == 0) return 1;
		if (height_reg > bmf_pkg::MAX_HEIGHT) return bmf_pkg::MAX_HEIGHT;
		return height_reg;
	endfunction

	function automatic logic [bmf_pkg::PIX_W-1:0] box_mean(int cx, int cy, int w, int h);
		int x0, y0, x1, y1, s, n;
		x0 = (cx >= RADIUS) ? cx - RADIUS : 0;
		y0 = (cy >= RADIUS) ? cy - RADIUS : 0;
		x1 = (cx + RADIUS < w) ? cx + RADIUS : w - 1;
		y1 = (cy + RADIUS < h) ? cy + RADIUS : h - 1;
		s = 0;
		n = 0;
		for (int yy = y0; yy <= y1; yy++)
			for (int xx = x0; xx <= x1; xx++) begin
				s += line_mem[(yy % WIN_ROWS) * MAX_WIDTH + xx];
				n++;
			end
		return bmf_pkg::PIX_W'(s / n);
	endfunction

	// centres finished along one axis when position p of extent n arrives
	function automatic bit centre_range(int p, int n, output int lo, output int hi);
		lo = 0;
		hi = 0;
		if (p + 1 < n) begin
			if (p < RADIUS) return 0;
			lo = p - RADIUS;
			hi = p - RADIUS;
			return 1;
		end
		lo = (p >= RADIUS) ? p - RADIUS : 0;
		hi = p;
		return 1;
	endfunction

	task automatic take_pixel(logic [bmf_pkg::PIX_W-1:0] v);
		int w, h, x, y, xl, xh, yl, yh;
		mean_word_t m;
		w = span_width();
		h = span_height();
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		y = row_pos;
		line_mem[(y % WIN_ROWS) * MAX_WIDTH + x] = v;
		if (centre_range(x, w, xl, xh) && centre_range(y, h, yl, yh)) begin
			for (int cy = yl; cy <= yh; cy++)
				for (int cx = xl; cx <= xh; cx++) begin
					m.mean = box_mean(cx, cy, w, h);
					m.col  = 8'(cx);
					m.row  = bmf_pkg::ROW_W'(cy);
					m.last = (cy == yh) && (cx == xh);
					mean_q.push_back(m);
				end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mean_word_t e;
		if (!arst_n) begin
			mean_q.delete();
			foreach (line_mem[i]) line_mem[i] = '0;
			width_reg  = 256;
			height_reg = 256;
			col_pos    = 0;
			row_pos    = 0;
			fail_cnt   <= 0;
			pending    <= 0;
			result_cnt <= 0;
		end else begin
			if (res.valid && res.ready) begin
				result_cnt <= result_cnt + 1;
				if (mean_q.size() == 0) begin
					$error("unexpected result word col %0d row %0d", res.center_col,
						res.center_row);
					fail_cnt <= fail_cnt + 1;
				end else begin
					e = mean_q.pop_front();
					if (res.mean_value !== e.mean)
						$error("mean_value expected %0d actual %0d", e.mean, res.mean_value);
					if (res.center_col !== e.col)
						$error("center_col expected %0d actual %0d", e.col, res.center_col);
					if (res.center_row !== e.row)
						$error("center_row expected %0d actual %0d", e.row, res.center_row);
					if (res.last_of_run !== e.last)
						$error("last_of_run expected %0d actual %0d", e.last, res.last_of_run);
					if (res.mean_value !== e.mean || res.center_col !== e.col ||
						res.center_row !== e.row || res.last_of_run !== e.last)
						fail_cnt <= fail_cnt + 1;
				end
			end
			if (pix.valid && pix.ready) take_pixel(pix.pixel_in);
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == bmf_pkg::CFG_IMAGE_WIDTH)
					width_reg = cfg.data[bmf_pkg::WID_CFG_W-1:0];
				else if (cfg.index == bmf_pkg::CFG_IMAGE_HEIGHT)
					height_reg = cfg.data[bmf_pkg::HGT_W-1:0];
			end
			pending <= mean_q.size();
		end
	end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top for box_mean_filter_clipped: clock, reset, pixel and config stimulus,
// result back-pressure and the verdict. Depends on bmf_pkg, bmf_if and bmf_checker.
`timescale 1ns / 1ps
module tb_top;

	localparam int WATCH_LIMIT = 6000;
	localparam int DRAIN_WAIT  = 150;

	logic clk;
	logic arst_n;
	int   fail_cnt, pending, result_cnt;
	int   pix_sent, idle_cycles, geo_cnt;
	bit   calm, hold_req;

	bmf_pix_if         pix_ch();
	bmf_res_if #(8)    res_ch();
	bmf_cfg_if         cfg_ch();

	box_mean_filter_clipped #(.RADIUS(3), .MAX_WIDTH(256)) dut (
		.clk(clk), .arst_n(arst_n), .pix(pix_ch), .res(res_ch), .cfg(cfg_ch)
	);

	bmf_checker #(.RADIUS(3), .MAX_WIDTH(256)) chk (
		.clk(clk), .arst_n(arst_n), .pix(pix_ch), .res(res_ch), .cfg(cfg_ch),
		.fail_cnt(fail_cnt), .pending(pending), .result_cnt(result_cnt)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", WATCH_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result back-pressure
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(logic [bmf_pkg::PIX_W-1:0] v);
		pix_ch.valid    <= 1'b1;
		pix_ch.pixel_in <= v;
		do @(posedge clk); while (!pix_ch.ready);
		pix_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [bmf_pkg::CFG_IDX_W-1:0] idx,
		logic [bmf_pkg::CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(int w, int h);
		wait_idle();
		write_reg(bmf_pkg::CFG_IMAGE_WIDTH, bmf_pkg::CFG_DATA_W'(w));
		write_reg(bmf_pkg::CFG_IMAGE_HEIGHT, bmf_pkg::CFG_DATA_W'(h));
		geo_cnt++;
	endtask

	task automatic send_frames(int w, int h, int n);
		for (int i = 0; i < w * h * n; i++)
			send_pixel(bmf_pkg::PIX_W'($urandom_range(0, 255)));
	endtask

	initial begin
		pix_ch.valid    = 1'b0;
		pix_ch.pixel_in = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = bmf_pkg::CFG_IMAGE_WIDTH;
		cfg_ch.data     = '0;
		arst_n          = 1'b0;
		idle_cycles     = 0;
		pix_sent        = 0;
		geo_cnt         = 0;
		calm            = 0;
		hold_req        = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as one: every pixel is a whole frame
		set_geometry(0, 0);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		send_pixel(8'h01);
		// tiny image, window clips on both sides
		set_geometry(3, 2);
		for (int i = 0; i < 6; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
		// oversize width saturates to the line store width
		set_geometry(300, 1);
		send_frames(256, 1, 1);
		// receiver stalled long
		set_geometry(16, 2);
		hold_req = 1;
		send_frames(16, 2, 1);
		// oversize height, then a mid-frame shrink that wraps the row counter
		set_geometry(2, 8191);
		send_frames(2, 6, 1);
		wait_idle();
		write_reg(bmf_pkg::CFG_IMAGE_WIDTH, 13'd10);
		write_reg(bmf_pkg::CFG_IMAGE_HEIGHT, 13'd5);
		geo_cnt++;
		// last part runs with no idling on either side
		calm = 1;
		send_frames(10, 5, 1);
		wait_idle();

		$display("%0d pixels over %0d geometries, %0d means checked", pix_sent, geo_cnt,
			result_cnt);
		if (pending != 0) $error("%0d expected means never arrived", pending);
		if (fail_cnt == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_if.sv
rtl/bmf_ctrl.sv
rtl/bmf_datapath.sv
rtl/box_mean_filter_clipped.sv
verif/bmf_checker.sv
verif/tb_top.sv
